// ----- rtl/core/reversing_contactor_interlock_top_assert.svh -----
// ----------------------------------------------------------------------------
// Reversing contactor interlock - assertion macros
// Clocked, reset-qualified property wrappers used by the top level's interlock checks.
// ----------------------------------------------------------------------------
`ifndef REVERSING_CONTACTOR_INTERLOCK_TOP_ASSERT_SVH
`define REVERSING_CONTACTOR_INTERLOCK_TOP_ASSERT_SVH

// condition must never hold at a clock edge out of reset
`define RCI_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("interlock assertion failed: forbidden condition");

// consequent must hold in the same cycle as the antecedent
`define RCI_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("interlock assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define RCI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("interlock assertion failed: next-cycle implication");

`endif

// ----- rtl/core/rci_pkg.sv -----
// ----------------------------------------------------------------------------
// Reversing contactor interlock - package
// Payload and state types, register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rci_pkg;

  // register map, word index into the configuration space
  typedef enum logic [2:0] {
    RegInverterMode     = 3'd0,
    RegContactorOffTick = 3'd1,
    RegUpOffTick        = 3'd2,
    RegDownOffTick      = 3'd3,
    RegContactorOnTick  = 3'd4,
    RegWeldHoldTick     = 3'd5
  } rci_reg_e;

  localparam int unsigned ApbAddrWidth = 5;
  localparam int unsigned ApbDataWidth = 32;

  // register reset values
  localparam logic       InverterModeRst     = 1'b0;
  localparam logic [3:0] ContactorOffTickRst = 4'd4;
  localparam logic [3:0] UpOffTickRst        = 4'd3;
  localparam logic [3:0] DownOffTickRst      = 4'd3;
  localparam logic [3:0] ContactorOnTickRst  = 4'd0;
  localparam logic [7:0] WeldHoldTickRst     = 8'd60;

  // one control tick
  typedef struct packed {
    logic run_open;
    logic run_close;
    logic phase_one_seen;
    logic phase_two_seen;
    logic stop_main;
    logic stop_lid;
    logic stop_display;
  } rci_in_t;

  // one result
  typedef struct packed {
    logic contactor_drive;
    logic up_drive;
    logic down_drive;
    logic output_fault;
    logic weld_fault;
    logic stop_request;
    logic door_timer_reload;
  } rci_out_t;

  // configuration register file contents
  typedef struct packed {
    logic       inverter_mode;
    logic [3:0] contactor_off_ticks;
    logic [3:0] up_off_ticks;
    logic [3:0] down_off_ticks;
    logic [3:0] contactor_on_ticks;
    logic [7:0] weld_hold_ticks;
  } rci_cfg_t;

  // interlock state carried from tick to tick
  typedef struct packed {
    logic       contactor;
    logic       up;
    logic       down;
    logic [3:0] contactor_off_cnt;
    logic [3:0] up_off_cnt;
    logic [3:0] down_off_cnt;
    logic [3:0] contactor_on_cnt;
    logic [7:0] weld_hold_cnt;
    logic       output_fault;
    logic       weld_fault;
  } rci_state_t;

  // saturating decrements
  function automatic logic [3:0] dec_sat4(input logic [3:0] v);
    return (v != 4'd0) ? v - 4'd1 : 4'd0;
  endfunction

  function automatic logic [7:0] dec_sat8(input logic [7:0] v);
    return (v != 8'd0) ? v - 8'd1 : 8'd0;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rci_in_if.sv -----
// ----------------------------------------------------------------------------
// Reversing contactor interlock - input channel
// Valid/ready channel carrying one control tick per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rci_in_if
  import rci_pkg::*;
  ();

  logic    valid;
  logic    ready;
  rci_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/rci_out_if.sv -----
// ----------------------------------------------------------------------------
// Reversing contactor interlock - result channel
// Valid/ready channel carrying one drive and status word per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rci_out_if
  import rci_pkg::*;
  ();

  logic     valid;
  logic     ready;
  rci_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/rci_apb_regs.sv -----
// ----------------------------------------------------------------------------
// Reversing contactor interlock - configuration registers
// APB write/read access to the timing and mode registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_apb_regs
  import rci_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ApbAddrWidth-1:0] paddr,
  input  wire logic [ApbDataWidth-1:0] pwdata,
  output      logic [ApbDataWidth-1:0] prdata,
  output      logic                    pready,
  output      rci_cfg_t                cfg_o
);

  rci_cfg_t cfg_q;
  rci_cfg_t cfg_d;
  logic     wr_en;
  rci_reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = rci_reg_e'(paddr[4:2]);

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegInverterMode:     cfg_d.inverter_mode       = pwdata[0];
        RegContactorOffTick: cfg_d.contactor_off_ticks = pwdata[3:0];
        RegUpOffTick:        cfg_d.up_off_ticks        = pwdata[3:0];
        RegDownOffTick:      cfg_d.down_off_ticks      = pwdata[3:0];
        RegContactorOnTick:  cfg_d.contactor_on_ticks  = pwdata[3:0];
        RegWeldHoldTick:     cfg_d.weld_hold_ticks     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inverter_mode       <= InverterModeRst;
      cfg_q.contactor_off_ticks <= ContactorOffTickRst;
      cfg_q.up_off_ticks        <= UpOffTickRst;
      cfg_q.down_off_ticks      <= DownOffTickRst;
      cfg_q.contactor_on_ticks  <= ContactorOnTickRst;
      cfg_q.weld_hold_ticks     <= WeldHoldTickRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegInverterMode:     prdata = ApbDataWidth'(cfg_q.inverter_mode);
      RegContactorOffTick: prdata = ApbDataWidth'(cfg_q.contactor_off_ticks);
      RegUpOffTick:        prdata = ApbDataWidth'(cfg_q.up_off_ticks);
      RegDownOffTick:      prdata = ApbDataWidth'(cfg_q.down_off_ticks);
      RegContactorOnTick:  prdata = ApbDataWidth'(cfg_q.contactor_on_ticks);
      RegWeldHoldTick:     prdata = ApbDataWidth'(cfg_q.weld_hold_ticks);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/rci_seq_step.sv -----
// ----------------------------------------------------------------------------
// Reversing contactor interlock - tick logic
// Next state and result for one control tick, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_seq_step
  import rci_pkg::*;
(
  input  wire rci_state_t state_i,
  input  wire rci_cfg_t   cfg_i,
  input  wire rci_in_t    item_i,
  output      rci_state_t state_o,
  output      rci_out_t   result_o
);

  rci_state_t s;
  logic       want;
  logic       other;
  logic [3:0] other_cnt;
  logic       stop_req;
  logic       reload;
  logic       any_stop;

  assign any_stop = item_i.stop_main | item_i.stop_lid | item_i.stop_display;

  always_comb begin
    s         = state_i;
    want      = 1'b0;
    other     = 1'b0;
    other_cnt = '0;
    stop_req  = 1'b0;
    reload    = 1'b0;

    // counters run down every tick
    s.contactor_off_cnt = dec_sat4(state_i.contactor_off_cnt);
    s.up_off_cnt        = dec_sat4(state_i.up_off_cnt);
    s.down_off_cnt      = dec_sat4(state_i.down_off_cnt);
    s.contactor_on_cnt  = dec_sat4(state_i.contactor_on_cnt);
    s.weld_hold_cnt     = dec_sat8(state_i.weld_hold_cnt);

    if (!cfg_i.inverter_mode) begin
      // dead times held at full length while their relay is on
      if (state_i.contactor) s.contactor_off_cnt = cfg_i.contactor_off_ticks;
      if (state_i.up)        s.up_off_cnt        = cfg_i.up_off_ticks;
      if (state_i.down)      s.down_off_cnt      = cfg_i.down_off_ticks;

      // fold the two directions onto wanted / other relay
      want      = item_i.run_open ? s.up : s.down;
      other     = item_i.run_open ? s.down : s.up;
      other_cnt = item_i.run_open ? s.down_off_cnt : s.up_off_cnt;

      if (item_i.run_open ^ item_i.run_close) begin
        // sequence toward the requested direction
        if (s.contactor && want) begin
          s.contactor = 1'b1;
        end else if (s.contactor && other) begin
          s.contactor = 1'b0;
        end else if (s.contactor_off_cnt == 4'd0) begin
          if (other) begin
            other = 1'b0;
          end else if (other_cnt == 4'd0) begin
            if (want) begin
              if (s.contactor_on_cnt == 4'd0) s.contactor = 1'b1;
            end else begin
              want               = 1'b1;
              s.contactor_on_cnt = cfg_i.contactor_on_ticks;
            end
          end
        end
      end else begin
        // no request or conflicting requests: stop the motor; a conflict also sets output fault
        if (item_i.run_open) s.output_fault = 1'b1;
        if (!s.contactor && (s.contactor_off_cnt == 4'd0)) begin
          want  = 1'b0;
          other = 1'b0;
        end else begin
          s.contactor = 1'b0;
        end
      end

      s.up   = item_i.run_open ? want : other;
      s.down = item_i.run_open ? other : want;

      // weld check on the updated contactor
      if (!s.contactor) begin
        if ((s.weld_hold_cnt == 8'd0) && (item_i.phase_one_seen || item_i.phase_two_seen)) begin
          s.weld_fault = 1'b1;
          s.up         = 1'b0;
          s.down       = 1'b0;
          stop_req     = 1'b1;
        end
      end else begin
        s.weld_hold_cnt = cfg_i.weld_hold_ticks;
        reload          = 1'b1;
      end
      if (any_stop) s.weld_fault = 1'b0;
    end
  end

  assign state_o = s;

  assign result_o.contactor_drive   = s.contactor;
  assign result_o.up_drive          = s.up;
  assign result_o.down_drive        = s.down;
  assign result_o.output_fault      = s.output_fault;
  assign result_o.weld_fault        = s.weld_fault;
  assign result_o.stop_request      = stop_req;
  assign result_o.door_timer_reload = reload;

endmodule

`default_nettype wire

// ----- rtl/core/reversing_contactor_interlock_top.sv -----
// A tick transfer is captured in the input register, processed by the tick logic
// and shown from the result register. Throughput: one tick per cycle while the
// result register is free or its result is taken, set by the single state update.
// Reset (asynchronous, active low): relays and flags clear, dead-time counters
// clear except the contactor-off counter, which loads its register reset
// value; configuration registers return to their reset values.
// ----------------------------------------------------------------------------
// Reversing contactor interlock - top level
// Input register, tick logic with interlock state, result register, APB regs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "reversing_contactor_interlock_top_assert.svh"

module reversing_contactor_interlock_top
  import rci_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  rci_in_if.sink                       in_i,
  rci_out_if.source                    out_o,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ApbAddrWidth-1:0] paddr,
  input  wire logic [ApbDataWidth-1:0] pwdata,
  output      logic [ApbDataWidth-1:0] prdata,
  output      logic                    pready
);

  rci_cfg_t   cfg;
  rci_in_t    in_q;
  logic       in_valid_q;
  rci_out_t   out_q;
  rci_out_t   out_d;
  logic       out_valid_q;
  rci_state_t state_q;
  rci_state_t state_d;
  logic       advance;
  logic       in_xfer;

  // configuration registers
  rci_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake control
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_i.data;
    end
  end

  // tick logic
  rci_seq_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  // interlock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.contactor         <= 1'b0;
      state_q.up                <= 1'b0;
      state_q.down              <= 1'b0;
      state_q.contactor_off_cnt <= ContactorOffTickRst;
      state_q.up_off_cnt        <= 4'd0;
      state_q.down_off_cnt      <= 4'd0;
      state_q.contactor_on_cnt  <= 4'd0;
      state_q.weld_hold_cnt     <= 8'd0;
      state_q.output_fault      <= 1'b0;
      state_q.weld_fault        <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // interlock checks
  `RCI_ASSERT_NEVER(a_relays_exclusive, state_q.up && state_q.down)
  `RCI_ASSERT_SAME(a_contactor_needs_dir, state_q.contactor, state_q.up || state_q.down)
  `RCI_ASSERT_SAME(a_weld_stop_drops_all, out_valid_q && out_q.stop_request,
                   !out_q.contactor_drive && !out_q.up_drive && !out_q.down_drive)
  `RCI_ASSERT_NEXT(a_state_holds_when_idle, !advance, $stable(state_q))

endmodule

`default_nettype wire
